[src/aou_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aou_pkg
// Shared constants, register codes and the iterative root and divide steps of
// the fixed-point Adam weight update.
// ----------------------------------------------------------------------------
package aou_pkg;

    localparam int ITER                  = 4;     // root or quotient bits per stage
    localparam int DEFAULT_ELEMENT_COUNT = 1024;

    localparam logic [23:0] RATE_RESET = 24'd16777;
    localparam logic [15:0] B1_RESET   = 16'd58982;
    localparam logic [15:0] B2_RESET   = 16'd65470;
    localparam logic [15:0] EPS_RESET  = 16'd1;

    localparam logic [32:0]        ONE_Q32  = 33'h1_0000_0000;
    localparam logic [47:0]        MH_CAP   = 48'h8000_0000_0000;
    localparam logic [33:0]        STEP_CAP = 34'h2_0000_0000;
    localparam logic signed [31:0] W_MAX    = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] W_MIN    = 32'sh8000_0000;

    typedef enum logic [1:0] {
        CFG_STEP_RATE,
        CFG_FIRST_DECAY,
        CFG_SECOND_DECAY,
        CFG_STABILIZER
    } t_cfg_idx;

    // digit-by-digit square root, radicand consumed two bits at a time from the top
    typedef struct packed {
        logic [63:0] x;
        logic [35:0] rem;
        logic [31:0] root;
    } t_sqrt;

    // restoring division, dividend bits shifted in from the top of num
    typedef struct packed {
        logic [63:0] num;
        logic [50:0] rem;
        logic [63:0] q;
        logic [49:0] d;
    } t_div;

    function automatic t_sqrt sqrt_iter(input t_sqrt s_in);
        t_sqrt       s;
        logic [35:0] trial;
        s     = s_in;
        trial = '0;
        for (int i = 0; i < ITER; i++) begin
            s.rem = {s.rem[33:0], s.x[63:62]};
            s.x   = {s.x[61:0], 2'b00};
            trial = {2'b00, s.root, 2'b01};
            if (s.rem >= trial) begin
                s.rem  = s.rem - trial;
                s.root = {s.root[30:0], 1'b1};
            end else begin
                s.root = {s.root[30:0], 1'b0};
            end
        end
        return s;
    endfunction

    function automatic t_div div_iter(input t_div d_in);
        t_div dv;
        logic ge;
        dv = d_in;
        ge = 1'b0;
        for (int i = 0; i < ITER; i++) begin
            dv.rem = {dv.rem[49:0], dv.num[63]};
            dv.num = {dv.num[62:0], 1'b0};
            ge     = (dv.rem >= {1'b0, dv.d});
            dv.q   = {dv.q[62:0], ge};
            if (ge) begin
                dv.rem = dv.rem - {1'b0, dv.d};
            end
        end
        return dv;
    endfunction

endpackage

[src/adam_optimizer_update.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adam_optimizer_update
// Fixed-point Adam update of one weight element per word, with per-element
// first and second moment memories and running decay powers.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries index, weight, gradient
//   and a step-begin mark; output channel (o_out_valid / i_out_ready) returns
//   index, saturated weight and a clip flag, one result word per input word,
//   in order. Registers must be written through i_cfg_we / i_cfg_index /
//   i_cfg_data only while the block is idle; the block does not enforce this.
//   A word accepted into r_p[0] moves through the stage registers to r_p[LAST].
//   Throughput: one word per cycle, outside stalls and the clear. The moment
//   read-modify-write closes in a single stage with a forward from the
//   following stage, so words for the same element may run back to back.
//   Reset: after i_rst_n is released the moment memories are zeroed, one
//   entry per cycle up to ELEMENT_COUNT-1; o_in_ready stays low meanwhile.
//   Stall: the whole pipeline holds while the output word waits; a new word
//   is taken outside the clear whenever the last stage is empty or draining.
// ----------------------------------------------------------------------------
module adam_optimizer_update #(
    parameter int ELEMENT_COUNT = aou_pkg::DEFAULT_ELEMENT_COUNT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [9:0]         i_element_index,
    input  logic signed [31:0] i_weight_in,
    input  logic signed [31:0] i_gradient_in,
    input  logic               i_step_begin,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [9:0]         o_element_out,
    output logic signed [31:0] o_weight_out,
    output logic               o_clipped,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data
);

    localparam int AW = (ELEMENT_COUNT > 1) ? $clog2(ELEMENT_COUNT) : 1;

    localparam int ST_PREP  = 1;
    localparam int ST_VMUL  = 2;
    localparam int ST_UPD   = 3;
    localparam int ST_ABS   = 4;
    localparam int R_FIRST  = 2;
    localparam int R_LAST   = 9;
    localparam int A_FIRST  = 5;
    localparam int A_LAST   = 16;
    localparam int S_FIRST  = 5;
    localparam int S_LAST   = 12;
    localparam int ST_BINIT = 13;
    localparam int B_FIRST  = 14;
    localparam int B_LAST   = 25;
    localparam int ST_DEN   = 26;
    localparam int ST_CINIT = 27;
    localparam int C_FIRST  = 28;
    localparam int C_LAST   = 42;
    localparam int ST_MUL   = 43;
    localparam int ST_STEP  = 44;
    localparam int LAST     = 45;

    typedef struct packed {
        logic               vld;
        logic [9:0]         idx;
        logic [9:0]         red;
        logic [AW-1:0]      slot;
        logic signed [31:0] w;
        logic signed [31:0] g;
        logic [32:0]        pow1;
        logic [32:0]        pow2;
        logic signed [49:0] cg1;
        logic [63:0]        g2;
        logic [48:0]        hic;
        logic [48:0]        loc;
        logic [32:0]        d1;
        logic               nob1;
        logic               nob2;
        logic signed [31:0] m;
        logic [63:0]        v;
        logic               mneg;
        logic [31:0]        am;
        aou_pkg::t_sqrt     sr;
        aou_pkg::t_sqrt     sq;
        aou_pkg::t_div      da;
        logic               a_ovf;
        aou_pkg::t_div      db;
        logic [48:0]        den;
        logic [47:0]        mh;
        aou_pkg::t_div      dc;
        logic               c_ovf;
        logic [55:0]        plo;
        logic [52:0]        phi;
        logic [33:0]        step;
        logic signed [31:0] wout;
        logic               clip;
    } t_pipe;

    // partial modulo: subtract shifted copies of the element count
    function automatic logic [9:0] mod_part(input logic [9:0] x_in, input int hi_sh,
                                            input int lo_sh);
        logic [9:0]  x;
        logic [31:0] t;
        x = x_in;
        t = '0;
        for (int s = 9; s >= 0; s--) begin
            t = 32'(ELEMENT_COUNT) << s;
            if (s <= hi_sh && s >= lo_sh && {22'b0, x} >= t) begin
                x = x - t[9:0];
            end
        end
        return x;
    endfunction

    logic [23:0] r_rate;
    logic [15:0] r_b1;
    logic [15:0] r_b2;
    logic [15:0] r_eps;
    logic [32:0] r_pow1;
    logic [32:0] r_pow2;
    logic [32:0] n_pow1;
    logic [32:0] n_pow2;
    logic [48:0] pw1;
    logic [48:0] pw2;
    logic [16:0] c1;
    logic [16:0] c2;

    t_pipe r_p [0:LAST];
    t_pipe n_p [0:LAST];

    logic               en;
    logic               accept;
    logic               r_clearing;
    logic [AW-1:0]      r_clr_addr;
    logic               w_we;
    logic [AW-1:0]      w_addr;
    logic signed [31:0] w_m;
    logic [63:0]        w_v;
    logic signed [31:0] r_mrd_m;
    logic [63:0]        r_mrd_v;

    logic signed [31:0] mem_m [0:ELEMENT_COUNT-1];
    logic [63:0]        mem_v [0:ELEMENT_COUNT-1];

    assign en         = !r_p[LAST].vld || i_out_ready;
    assign o_in_ready = en && !r_clearing;
    assign accept     = i_in_valid && o_in_ready;

    assign c1     = 17'h1_0000 - {1'b0, r_b1};
    assign c2     = 17'h1_0000 - {1'b0, r_b2};
    assign pw1    = r_pow1 * r_b1 + 49'd32768;
    assign pw2    = r_pow2 * r_b2 + 49'd32768;
    assign n_pow1 = pw1[48:16];
    assign n_pow2 = pw2[48:16];

    always_comb begin
        logic [31:0]        ag;
        logic               fwd;
        logic signed [31:0] m_old;
        logic [63:0]        v_old;
        logic signed [49:0] mix;
        logic signed [33:0] m_rnd;
        logic [49:0]        v_hi;
        logic [49:0]        v_lo;
        logic [49:0]        v_lo_r;
        logic [63:0]        num;
        logic [47:0]        root48;
        logic [60:0]        ratio;
        logic [84:0]        prod;
        logic [60:0]        step_full;
        logic signed [35:0] res;
        logic [31:0]        t32;

        ag        = '0;
        fwd       = 1'b0;
        m_old     = '0;
        v_old     = '0;
        mix       = '0;
        m_rnd     = '0;
        v_hi      = '0;
        v_lo      = '0;
        v_lo_r    = '0;
        num       = '0;
        root48    = '0;
        ratio     = '0;
        prod      = '0;
        step_full = '0;
        res       = '0;
        t32       = '0;

        n_p[0]      = r_p[0];
        n_p[0].vld  = accept;
        n_p[0].idx  = i_element_index;
        n_p[0].red  = mod_part(i_element_index, 9, 5);
        n_p[0].w    = i_weight_in;
        n_p[0].g    = i_gradient_in;
        // the power update lands before this word is processed
        n_p[0].pow1 = i_step_begin ? n_pow1 : r_pow1;
        n_p[0].pow2 = i_step_begin ? n_pow2 : r_pow2;

        for (int k = 1; k <= LAST; k++) begin
            n_p[k] = r_p[k-1];

            if (k == ST_PREP) begin
                n_p[k].red  = mod_part(r_p[k-1].red, 4, 0);
                t32         = {22'b0, n_p[k].red};
                n_p[k].slot = t32[AW-1:0];
                n_p[k].cg1  = $signed({1'b0, c1}) * r_p[k-1].g;
                ag          = r_p[k-1].g[31] ? (32'd0 - 32'(r_p[k-1].g))
                                             : 32'(r_p[k-1].g);
                n_p[k].g2   = ag * ag;
                n_p[k].d1   = aou_pkg::ONE_Q32 - r_p[k-1].pow1;
                n_p[k].nob1 = r_p[k-1].pow1[32];
                n_p[k].nob2 = r_p[k-1].pow2[32];
                n_p[k].sr.x    = {1'b0, aou_pkg::ONE_Q32 - r_p[k-1].pow2, 30'b0};
                n_p[k].sr.rem  = '0;
                n_p[k].sr.root = '0;
            end

            if (k == ST_VMUL) begin
                n_p[k].hic = c2 * r_p[k-1].g2[63:32];
                n_p[k].loc = c2 * r_p[k-1].g2[31:0];
            end

            if (k >= R_FIRST && k <= R_LAST) begin
                n_p[k].sr = aou_pkg::sqrt_iter(r_p[k-1].sr);
            end

            if (k == ST_UPD) begin
                // the word just ahead wrote this element at the edge we read it
                fwd   = r_p[k].vld && (r_p[k].slot == r_p[k-1].slot);
                m_old = fwd ? r_p[k].m : r_mrd_m;
                v_old = fwd ? r_p[k].v : r_mrd_v;
                mix   = $signed({1'b0, r_b1}) * m_old + r_p[k-1].cg1;
                m_rnd = 34'((mix + 50'sd32768) >>> 16);
                if (m_rnd > 34'sd2147483647) begin
                    n_p[k].m = aou_pkg::W_MAX;
                end else if (m_rnd < -34'sd2147483648) begin
                    n_p[k].m = aou_pkg::W_MIN;
                end else begin
                    n_p[k].m = m_rnd[31:0];
                end
                v_hi     = r_b2 * v_old[63:32] + r_p[k-1].hic;
                v_lo     = r_b2 * v_old[31:0] + r_p[k-1].loc;
                v_lo_r   = (v_lo + 50'd32768) >> 16;
                n_p[k].v = {v_hi[47:0], 16'b0} + {30'b0, v_lo_r[33:0]};
            end

            if (k == ST_ABS) begin
                n_p[k].mneg   = r_p[k-1].m[31];
                n_p[k].am     = r_p[k-1].m[31] ? (32'd0 - 32'(r_p[k-1].m))
                                               : 32'(r_p[k-1].m);
                num           = {n_p[k].am, 32'b0} + {32'b0, r_p[k-1].d1[32:1]};
                n_p[k].da.rem = {35'b0, num[63:48]};
                n_p[k].da.num = {num[47:0], 16'b0};
                n_p[k].da.q   = '0;
                n_p[k].da.d   = {17'b0, r_p[k-1].d1};
                n_p[k].a_ovf  = ({17'b0, num[63:48]} >= r_p[k-1].d1);
                n_p[k].sq.x    = r_p[k-1].v;
                n_p[k].sq.rem  = '0;
                n_p[k].sq.root = '0;
            end

            if (k >= A_FIRST && k <= A_LAST) begin
                n_p[k].da = aou_pkg::div_iter(r_p[k-1].da);
            end

            if (k >= S_FIRST && k <= S_LAST) begin
                n_p[k].sq = aou_pkg::sqrt_iter(r_p[k-1].sq);
            end

            if (k == ST_BINIT) begin
                num = ({32'b0, r_p[k-1].sq.root} << 31)
                    + {33'b0, r_p[k-1].sr.root[31:1]};
                n_p[k].db.rem = {35'b0, num[63:48]};
                n_p[k].db.num = {num[47:0], 16'b0};
                n_p[k].db.q   = '0;
                n_p[k].db.d   = {18'b0, r_p[k-1].sr.root};
            end

            if (k >= B_FIRST && k <= B_LAST) begin
                n_p[k].db = aou_pkg::div_iter(r_p[k-1].db);
            end

            if (k == ST_DEN) begin
                root48     = r_p[k-1].nob2 ? {16'b0, r_p[k-1].sq.root}
                                           : r_p[k-1].db.q[47:0];
                n_p[k].den = {1'b0, root48} + {33'b0, r_eps};
                if (n_p[k].den == '0) begin
                    n_p[k].den = 49'd1;
                end
                if (r_p[k-1].nob1) begin
                    n_p[k].mh = {16'b0, r_p[k-1].am};
                end else if (r_p[k-1].a_ovf || r_p[k-1].da.q[47:0] > aou_pkg::MH_CAP) begin
                    n_p[k].mh = aou_pkg::MH_CAP;
                end else begin
                    n_p[k].mh = r_p[k-1].da.q[47:0];
                end
            end

            if (k == ST_CINIT) begin
                num           = {r_p[k-1].mh, 16'b0} + {16'b0, r_p[k-1].den[48:1]};
                n_p[k].dc.rem = {47'b0, num[63:60]};
                n_p[k].dc.num = {num[59:0], 4'b0};
                n_p[k].dc.q   = '0;
                n_p[k].dc.d   = {1'b0, r_p[k-1].den};
                // a ratio of 2^60 or more saturates the step for any nonzero rate
                n_p[k].c_ovf  = ({45'b0, num[63:60]} >= r_p[k-1].den);
            end

            if (k >= C_FIRST && k <= C_LAST) begin
                n_p[k].dc = aou_pkg::div_iter(r_p[k-1].dc);
            end

            if (k == ST_MUL) begin
                ratio      = r_p[k-1].c_ovf ? (61'd1 << 60) : {1'b0, r_p[k-1].dc.q[59:0]};
                n_p[k].plo = ratio[31:0] * r_rate;
                n_p[k].phi = ratio[60:32] * r_rate;
            end

            if (k == ST_STEP) begin
                prod      = {r_p[k-1].phi, 32'b0} + {29'b0, r_p[k-1].plo} + 85'd8388608;
                step_full = prod[84:24];
                n_p[k].step = (step_full > {27'b0, aou_pkg::STEP_CAP}) ? aou_pkg::STEP_CAP
                                                                      : step_full[33:0];
            end

            if (k == LAST) begin
                res = r_p[k-1].mneg ? 36'(r_p[k-1].w) + $signed({2'b0, r_p[k-1].step})
                                    : 36'(r_p[k-1].w) - $signed({2'b0, r_p[k-1].step});
                if (res > 36'sd2147483647) begin
                    n_p[k].wout = aou_pkg::W_MAX;
                    n_p[k].clip = 1'b1;
                end else if (res < -36'sd2147483648) begin
                    n_p[k].wout = aou_pkg::W_MIN;
                    n_p[k].clip = 1'b1;
                end else begin
                    n_p[k].wout = res[31:0];
                    n_p[k].clip = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= LAST; k++) begin
                r_p[k].vld <= 1'b0;
            end
        end else if (en) begin
            for (int k = 0; k <= LAST; k++) begin
                r_p[k] <= n_p[k];
            end
        end
    end

    // configuration and decay powers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= aou_pkg::RATE_RESET;
            r_b1   <= aou_pkg::B1_RESET;
            r_b2   <= aou_pkg::B2_RESET;
            r_eps  <= aou_pkg::EPS_RESET;
            r_pow1 <= aou_pkg::ONE_Q32;
            r_pow2 <= aou_pkg::ONE_Q32;
        end else begin
            if (i_cfg_we) begin
                unique case (aou_pkg::t_cfg_idx'(i_cfg_index))
                    aou_pkg::CFG_STEP_RATE:    r_rate <= i_cfg_data;
                    aou_pkg::CFG_FIRST_DECAY:  r_b1   <= i_cfg_data[15:0];
                    aou_pkg::CFG_SECOND_DECAY: r_b2   <= i_cfg_data[15:0];
                    aou_pkg::CFG_STABILIZER:   r_eps  <= i_cfg_data[15:0];
                endcase
            end
            if (accept && i_step_begin) begin
                r_pow1 <= n_pow1;
                r_pow2 <= n_pow2;
            end
        end
    end

    // zeroing pass over the moment memories after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == AW'(ELEMENT_COUNT - 1)) begin
                r_clearing <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    assign w_we   = r_clearing || (en && r_p[ST_UPD-1].vld);
    assign w_addr = r_clearing ? r_clr_addr : r_p[ST_UPD-1].slot;
    assign w_m    = r_clearing ? '0 : n_p[ST_UPD].m;
    assign w_v    = r_clearing ? '0 : n_p[ST_UPD].v;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem_m[w_addr] <= w_m;
            mem_v[w_addr] <= w_v;
        end
        if (en) begin
            r_mrd_m <= mem_m[r_p[ST_VMUL-1].slot];
            r_mrd_v <= mem_v[r_p[ST_VMUL-1].slot];
        end
    end

    assign o_out_valid   = r_p[LAST].vld;
    assign o_element_out = r_p[LAST].idx;
    assign o_weight_out  = r_p[LAST].wout;
    assign o_clipped     = r_p[LAST].clip;

`ifndef NO_ASSERTIONS
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !o_in_ready)
        else $error("word accepted during memory clear");

    a_clear_covers_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_clearing) |-> (r_clr_addr == AW'(ELEMENT_COUNT - 1)))
        else $error("memory clear ended early");

    a_power_le_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p[0].vld |-> (r_p[0].pow1 <= aou_pkg::ONE_Q32 && r_p[0].pow2 <= aou_pkg::ONE_Q32))
        else $error("decay power above one");

    a_step_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p[ST_STEP].vld |-> (r_p[ST_STEP].step <= aou_pkg::STEP_CAP))
        else $error("step above cap");

    a_clip_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_clipped) |->
            (o_weight_out == aou_pkg::W_MAX || o_weight_out == aou_pkg::W_MIN))
        else $error("clip flag without saturated weight");
`endif

endmodule

[sim/tb_adam_optimizer_update.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adam_optimizer_update
// Self-checking bench for the fixed-point Adam update: random and directed
// words with random idling on both channels, several register settings, and
// every result compared in order against a local predictor.
// ----------------------------------------------------------------------------
class adam_scoreboard;

    logic [23:0]        rate;
    logic [15:0]        b1;
    logic [15:0]        b2;
    logic [15:0]        eps;
    logic signed [31:0] m_store [1024];
    logic [63:0]        v_store [1024];
    logic [31:0]        steps;
    logic [63:0]        p1;
    logic [63:0]        p2;
    logic [9:0]         want_idx [$];
    logic [31:0]        want_w   [$];
    logic               want_clip[$];
    int                 errors;

    function void reset_state();
        rate = aou_pkg::RATE_RESET; b1 = aou_pkg::B1_RESET;
        b2 = aou_pkg::B2_RESET; eps = aou_pkg::EPS_RESET;
        foreach (m_store[i]) begin
            m_store[i] = '0;
            v_store[i] = '0;
        end
        steps = '0;
        p1 = 64'(aou_pkg::ONE_Q32);
        p2 = 64'(aou_pkg::ONE_Q32);
        errors = 0;
    endfunction

    function void write_reg(aou_pkg::t_cfg_idx idx, logic [23:0] val);
        case (idx)
            aou_pkg::CFG_STEP_RATE:    rate = val;
            aou_pkg::CFG_FIRST_DECAY:  b1 = val[15:0];
            aou_pkg::CFG_SECOND_DECAY: b2 = val[15:0];
            aou_pkg::CFG_STABILIZER:   eps = val[15:0];
            default: ;
        endcase
    endfunction

    function logic [63:0] isqrt(logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > x) bt = bt >> 2;
        while (bt != 0) begin
            if (x >= res + bt) begin
                x = x - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    function void note_input(logic [9:0] idx, logic signed [31:0] w,
                             logic signed [31:0] g, logic sb);
        logic signed [63:0]  mix, mm, res;
        logic [63:0]         ag, g2, vo, c2, hi, lo, vv, am, d1, mh, s, root, d2, r2;
        logic [63:0]         den, ratio, stp;
        logic [127:0]        wide;
        logic                clip;
        if (sb) begin
            steps = steps + 1;
            p1 = (p1 * b1 + 64'd32768) >> 16;
            p2 = (p2 * b2 + 64'd32768) >> 16;
        end
        mix = $signed({48'd0, b1}) * 64'(m_store[idx])
            + $signed(64'd65536 - b1) * 64'(g);
        mm = $signed(((64'(mix) + (64'd1 << 48)) + 64'd32768) >> 16) - (64'sd1 <<< 32);
        if (mm > 64'sd2147483647) mm = 64'sd2147483647;
        if (mm < -64'sd2147483648) mm = -64'sd2147483648;
        m_store[idx] = mm[31:0];
        ag = (g < 0) ? 64'(-64'(g)) : 64'(g);
        g2 = ag * ag;
        vo = v_store[idx];
        c2 = 64'd65536 - b2;
        hi = b2 * (vo >> 32) + c2 * (g2 >> 32);
        lo = b2 * (vo & 64'hffff_ffff) + c2 * (g2 & 64'hffff_ffff);
        vv = (hi << 16) + ((lo + 64'd32768) >> 16);
        v_store[idx] = vv;
        am = (mm < 0) ? 64'(-mm) : 64'(mm);
        if (p1 >= 64'(aou_pkg::ONE_Q32)) begin
            mh = am;
        end else begin
            d1 = 64'(aou_pkg::ONE_Q32) - p1;
            wide = ({64'd0, am} << 32) + d1 / 2;
            wide = wide / d1;
            mh = wide[63:0];
            if (wide > 128'(aou_pkg::MH_CAP)) mh = 64'(aou_pkg::MH_CAP);
        end
        if (mh > 64'(aou_pkg::MH_CAP)) mh = 64'(aou_pkg::MH_CAP);
        s = isqrt(vv);
        if (p2 >= 64'(aou_pkg::ONE_Q32)) begin
            root = s;
        end else begin
            d2 = 64'(aou_pkg::ONE_Q32) - p2;
            r2 = isqrt(d2 << 30);
            root = ((s << 31) + r2 / 2) / r2;
        end
        den = root + eps;
        if (den == 0) den = 1;
        ratio = ((mh << 16) + den / 2) / den;
        stp = (((ratio >> 32) * rate) << 8)
            + (((ratio & 64'hffff_ffff) * rate + (64'd1 << 23)) >> 24);
        if (stp > 64'(aou_pkg::STEP_CAP)) stp = 64'(aou_pkg::STEP_CAP);
        res = (mm < 0) ? 64'(w) + $signed(stp) : 64'(w) - $signed(stp);
        clip = 1'b0;
        if (res > 64'sd2147483647) begin
            res = 64'sd2147483647; clip = 1'b1;
        end
        if (res < -64'sd2147483648) begin
            res = -64'sd2147483648; clip = 1'b1;
        end
        want_idx.push_back(idx);
        want_w.push_back(res[31:0]);
        want_clip.push_back(clip);
    endfunction

    task report(string what);
        $display("mismatch at %0t: %s", $time, what);
        errors++;
    endtask

    task check_result(logic [9:0] idx, logic [31:0] w, logic clip);
        logic [9:0]  ei;
        logic [31:0] ew;
        logic        ec;
        if (want_idx.size() == 0) begin
            report($sformatf("unexpected word idx=%0d", idx));
            return;
        end
        ei = want_idx.pop_front();
        ew = want_w.pop_front();
        ec = want_clip.pop_front();
        if (idx !== ei) report($sformatf("index %0d, want %0d", idx, ei));
        if (w !== ew) report($sformatf("idx %0d weight %h, want %h", ei, w, ew));
        if (clip !== ec) report($sformatf("idx %0d clip %b, want %b", ei, clip, ec));
    endtask
endclass

module tb_adam_optimizer_update;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [9:0]         i_element_index = '0;
    logic signed [31:0] i_weight_in = '0;
    logic signed [31:0] i_gradient_in = '0;
    logic               i_step_begin = 1'b0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [9:0]         o_element_out;
    logic signed [31:0] o_weight_out;
    logic               o_clipped;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_index = '0;
    logic [23:0]        i_cfg_data = '0;

    adam_scoreboard scb;
    bit             calm;   // stretch with no idling

    always #2 i_clk = ~i_clk;

    adam_optimizer_update i_dut (.*);

    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready)
            scb.check_result(o_element_out, o_weight_out, o_clipped);
    end

    always @(negedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(99) >= 13);
    end

    task automatic write_reg(aou_pkg::t_cfg_idx idx, logic [23:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        scb.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // valid stays high between words; it drops only while idling or draining
    task automatic send_word(logic [9:0] idx, logic [31:0] w, logic [31:0] g, logic sb);
        while (!calm && $urandom_range(99) < 13) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_element_index <= idx;
        i_weight_in <= w;
        i_gradient_in <= g;
        i_step_begin <= sb;
        do @(posedge i_clk); while (!o_in_ready);
        scb.note_input(idx, w, g, sb);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (scb.want_idx.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_val();
        case ($urandom_range(5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $urandom_range(131072) - 65536;
            3: return $urandom_range(16777216) - 8388608;
            default: return $urandom;
        endcase
    endfunction

    // optimizer steps, each a marked first word then a run over a few elements
    task automatic random_steps(int words);
        int n;
        int base;
        n = 0;
        while (n < words) begin
            base = $urandom_range(1023);
            for (int k = 0; k < 1 + $urandom_range(15) && n < words; k++) begin
                if ($urandom_range(9) == 0)
                    send_word(10'($urandom), rand_val(), rand_val(),
                              1'($urandom_range(1)));
                else
                    send_word(10'(base + ($urandom_range(3) == 0 ? 0 : k)),
                              rand_val(), rand_val(), k == 0);
                n++;
            end
        end
    endtask

    initial begin
        #4_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        scb = new();
        scb.reset_state();
        calm = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // before any step: no bias correction, then the field extremes
        send_word(10'd0, 32'h0001_0000, 32'h0001_0000, 1'b0);
        send_word(10'd1023, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
        send_word(10'd5, 32'h8000_0000, 32'h7fff_ffff, 1'b1);
        send_word(10'd5, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
        send_word(10'd5, 32'h0, 32'h0, 1'b0);
        send_word(10'd1023, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
        send_word(10'd0, 32'h7fff_ffff, 32'hffff_0000, 1'b0);
        send_word(10'd512, 32'h0, 32'h0, 1'b0);
        drain();

        // zero denominator: zero epsilon and zero moments
        write_reg(aou_pkg::CFG_STABILIZER, 24'd0);
        write_reg(aou_pkg::CFG_STEP_RATE, 24'hff_ffff);
        write_reg(aou_pkg::CFG_FIRST_DECAY, 24'h00_ffff);
        write_reg(aou_pkg::CFG_SECOND_DECAY, 24'h00_ffff);
        send_word(10'd700, 32'h1234_5678, 32'h0, 1'b1);
        send_word(10'd700, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
        send_word(10'd701, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
        drain();

        write_reg(aou_pkg::CFG_FIRST_DECAY, 24'd0);
        write_reg(aou_pkg::CFG_SECOND_DECAY, 24'd0);
        write_reg(aou_pkg::CFG_STEP_RATE, 24'd0);
        write_reg(aou_pkg::CFG_STABILIZER, 24'hffff);
        send_word(10'd3, 32'h5, 32'h7fff_ffff, 1'b1);
        send_word(10'd4, 32'h5, 32'h8000_0000, 1'b1);
        drain();

        calm = 1'b1;
        write_reg(aou_pkg::CFG_STEP_RATE, 24'd16777);
        write_reg(aou_pkg::CFG_FIRST_DECAY, 24'd58982);
        write_reg(aou_pkg::CFG_SECOND_DECAY, 24'd65470);
        write_reg(aou_pkg::CFG_STABILIZER, 24'd1);
        random_steps(400);
        drain();
        calm = 1'b0;
        random_steps(400);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            write_reg(aou_pkg::CFG_STEP_RATE, 24'($urandom_range(24'hff_ffff)));
            write_reg(aou_pkg::CFG_FIRST_DECAY, 24'($urandom_range(16'hffff)));
            write_reg(aou_pkg::CFG_SECOND_DECAY, 24'($urandom_range(16'hffff)));
            write_reg(aou_pkg::CFG_STABILIZER, 24'($urandom_range(16'hffff)));
            random_steps(250);
            drain();
        end

        if (scb.errors == 0 && scb.want_idx.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
